@@ rtl/r2y_pkg.sv @@
// Shared types, Q0.16 coefficients and the saturation helper for the
// RGB to YUV 4:2:0 converter. No dependencies.
`default_nettype none

package r2y_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned POS_W  = 12;
    localparam int unsigned COEF_W = 16;
    localparam int unsigned PROD_W = PIX_W + COEF_W;   // 24
    localparam int unsigned LSUM_W = PROD_W + 1;       // luma sum, unsigned
    localparam int unsigned CSUM_W = PROD_W + 2;       // chroma sum, signed
    localparam int unsigned FRAC_W = 16;

    // BT.709 coefficients, real value * 65536
    localparam logic [COEF_W-1:0] Y_KR = 16'd13933;
    localparam logic [COEF_W-1:0] Y_KG = 16'd46871;
    localparam logic [COEF_W-1:0] Y_KB = 16'd4732;
    localparam logic [COEF_W-1:0] U_KR = 16'd6548;
    localparam logic [COEF_W-1:0] U_KG = 16'd22026;
    localparam logic [COEF_W-1:0] U_KB = 16'd28574;
    localparam logic [COEF_W-1:0] V_KR = 16'd40305;
    localparam logic [COEF_W-1:0] V_KG = 16'd36609;
    localparam logic [COEF_W-1:0] V_KB = 16'd3696;

    // 128 << 16
    localparam logic signed [CSUM_W-1:0] CHROMA_BIAS = 26'sd8388608;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
    } t_pixel_in;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] chroma_v;
        logic             chroma_valid;
    } t_pixel_out;

    // Control travelling alongside each request
    typedef struct packed {
        logic valid;
        logic chroma;
    } t_ctrl;

    typedef struct packed {
        logic [PROD_W-1:0] y_r;
        logic [PROD_W-1:0] y_g;
        logic [PROD_W-1:0] y_b;
        logic [PROD_W-1:0] u_r;
        logic [PROD_W-1:0] u_g;
        logic [PROD_W-1:0] u_b;
        logic [PROD_W-1:0] v_r;
        logic [PROD_W-1:0] v_g;
        logic [PROD_W-1:0] v_b;
    } t_prod;

    typedef struct packed {
        logic        [LSUM_W-1:0] y;
        logic signed [CSUM_W-1:0] u;
        logic signed [CSUM_W-1:0] v;
    } t_sum;

    // Floor a Q16 sum to an integer and clamp to 0..255
    function automatic logic [PIX_W-1:0] sat_q16(input logic signed [CSUM_W-1:0] acc);
        logic [CSUM_W-FRAC_W-1:0] int_part;
        int_part = acc[CSUM_W-1:FRAC_W];
        if (acc[CSUM_W-1])
            return '0;
        else if (int_part[CSUM_W-FRAC_W-2:PIX_W] != '0)
            return '1;
        else
            return int_part[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/r2y_mult.sv @@
// Stage 1: the nine coefficient products, registered.
// Depends on r2y_pkg.
`default_nettype none

module r2y_mult (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire r2y_pkg::t_ctrl    i_ctrl,
    input  wire r2y_pkg::t_pixel_in i_pixel,
    output r2y_pkg::t_ctrl         o_ctrl,
    output r2y_pkg::t_prod         o_prod
);
    import r2y_pkg::*;

    t_ctrl r_ctrl;
    t_prod r_prod;
    t_prod n_prod;

    always_comb begin
        n_prod.y_r = PROD_W'(Y_KR) * PROD_W'(i_pixel.red);
        n_prod.y_g = PROD_W'(Y_KG) * PROD_W'(i_pixel.green);
        n_prod.y_b = PROD_W'(Y_KB) * PROD_W'(i_pixel.blue);
        n_prod.u_r = PROD_W'(U_KR) * PROD_W'(i_pixel.red);
        n_prod.u_g = PROD_W'(U_KG) * PROD_W'(i_pixel.green);
        n_prod.u_b = PROD_W'(U_KB) * PROD_W'(i_pixel.blue);
        n_prod.v_r = PROD_W'(V_KR) * PROD_W'(i_pixel.red);
        n_prod.v_g = PROD_W'(V_KG) * PROD_W'(i_pixel.green);
        n_prod.v_b = PROD_W'(V_KB) * PROD_W'(i_pixel.blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_ctrl = r_ctrl;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/r2y_sum.sv @@
// Stage 2: per-channel sums of the products, chroma bias added, registered.
// Depends on r2y_pkg.
`default_nettype none

module r2y_sum (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire r2y_pkg::t_ctrl i_ctrl,
    input  wire r2y_pkg::t_prod i_prod,
    output r2y_pkg::t_ctrl      o_ctrl,
    output r2y_pkg::t_sum       o_sum
);
    import r2y_pkg::*;

    t_ctrl r_ctrl;
    t_sum  r_sum;
    t_sum  n_sum;

    always_comb begin
        n_sum.y = LSUM_W'(i_prod.y_r) + LSUM_W'(i_prod.y_g) + LSUM_W'(i_prod.y_b);
        n_sum.u = CHROMA_BIAS + $signed(CSUM_W'(i_prod.u_b))
                - $signed(CSUM_W'(i_prod.u_r)) - $signed(CSUM_W'(i_prod.u_g));
        n_sum.v = CHROMA_BIAS + $signed(CSUM_W'(i_prod.v_r))
                - $signed(CSUM_W'(i_prod.v_g)) - $signed(CSUM_W'(i_prod.v_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_ctrl = r_ctrl;
    assign o_sum  = r_sum;

endmodule

`default_nettype wire

@@ rtl/r2y_sat.sv @@
// Stage 3: floor and clamp each channel, blank chroma on odd positions,
// drive the output register. Depends on r2y_pkg.
`default_nettype none

module r2y_sat (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire r2y_pkg::t_ctrl i_ctrl,
    input  wire r2y_pkg::t_sum  i_sum,
    output logic                o_valid,
    output r2y_pkg::t_pixel_out o_result
);
    import r2y_pkg::*;

    logic       r_valid;
    t_pixel_out r_result;
    t_pixel_out n_result;

    always_comb begin
        n_result.luma         = sat_q16($signed(CSUM_W'(i_sum.y)));
        n_result.chroma_valid = i_ctrl.chroma;
        if (i_ctrl.chroma) begin
            n_result.chroma_u = sat_q16(i_sum.u);
            n_result.chroma_v = sat_q16(i_sum.v);
        end else begin
            n_result.chroma_u = '0;
            n_result.chroma_v = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ rtl/rgb_to_yuv420_converter.sv @@
// RGB888 to BT.709 YUV 4:2:0 converter, top level. Uses r2y_pkg, r2y_mult,
// r2y_sum and r2y_sat.
// Each accepted request passes the product, sum and output registers in turn.
// Throughput: one request per clock, set by the three-stage multiply/add/clamp
// pipeline; busy is never raised since every stage advances each cycle.
// Reset (i_rst_n, synchronous, active low) clears only the stage control (valid, chroma) bits.
`default_nettype none

module rgb_to_yuv420_converter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire r2y_pkg::t_pixel_in i_pixel,
    output logic                    o_valid,
    output r2y_pkg::t_pixel_out     o_result
);
    import r2y_pkg::*;

    t_ctrl s0_ctrl;
    t_ctrl s1_ctrl;
    t_ctrl s2_ctrl;
    t_prod s1_prod;
    t_sum  s2_sum;

    // Receiver takes every strobe, so the pipe never backs up
    assign busy = 1'b0;

    // Chroma sampled at the top-left pixel of each 2x2 block: only the
    // parity bits of the position matter.
    always_comb begin
        s0_ctrl.valid  = start && !busy;
        s0_ctrl.chroma = !i_pixel.column[0] && !i_pixel.row[0];
    end

    // Stage 1: nine 16x8 products
    r2y_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (s0_ctrl),
        .i_pixel (i_pixel),
        .o_ctrl  (s1_ctrl),
        .o_prod  (s1_prod)
    );

    // Stage 2: three-term sums with the +128 chroma bias in Q16
    r2y_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (s1_ctrl),
        .i_prod  (s1_prod),
        .o_ctrl  (s2_ctrl),
        .o_sum   (s2_sum)
    );

    // Stage 3: floor by 16 bits, clamp to 0..255, output register
    r2y_sat u_sat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (s2_ctrl),
        .i_sum    (s2_sum),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
